/* rtl/rsfs_pkg.sv */
// Shared constants, result codes and unit status type for the square factor search.
package rsfs_pkg;

  localparam int RADICAND_BITS_DEF = 31;
  localparam int KIND_W            = 2;
  localparam int FACTOR_W          = 16;
  localparam int MAX_RESULTS       = 64;

  localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAIR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;

  typedef struct packed {
    logic done;
    logic zero;
  } rsfs_stat_t;

endpackage

/* rtl/rsfs_isqrt.sv */
// Digit-serial integer square root, two radicand bits per cycle.
module rsfs_isqrt #(
  parameter int W = rsfs_pkg::RADICAND_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [W-1:0]             n,
  output logic [(W+1)/2-1:0]       root,
  output rsfs_pkg::rsfs_stat_t     stat
);
  import rsfs_pkg::*;

  localparam int H  = (W + 1) / 2;
  localparam int PW = 2 * H;
  localparam int CW = $clog2(H + 1);

  logic [PW-1:0] x_r, x_nxt;
  logic [H:0]    rem_r, rem_nxt;
  logic [H-1:0]  root_r, root_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [H+2:0]  rsh;
  logic [H+2:0]  trial;
  logic [H+2:0]  diff;
  logic          ge;

  assign rsh   = {rem_r, x_r[PW-1:PW-2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign diff  = rsh - trial;
  assign ge    = (rsh >= trial);

  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = PW'(n);
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CW'(H);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt    = {x_r[PW-3:0], 2'b00};
      rem_nxt  = ge ? diff[H:0] : rsh[H:0];
      root_nxt = {root_r[H-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root      = root_r;
  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

/* rtl/rsfs_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module rsfs_div #(
  parameter int W = rsfs_pkg::RADICAND_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [W-1:0]         dividend,
  input  logic [W-1:0]         divisor,
  output logic [W-1:0]         quot,
  output rsfs_pkg::rsfs_stat_t stat
);
  import rsfs_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    rsh;
  logic [W:0]    diff;
  logic          ge;

  assign rsh  = {r_r, q_r[W-1]};
  assign diff = rsh - {1'b0, d_r};
  assign ge   = (rsh >= {1'b0, d_r});

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[W-2:0], ge};
      r_nxt   = ge ? diff[W-1:0] : rsh[W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign quot      = q_r;
  assign stat.done = done_r;
  assign stat.zero = (r_r == '0);

endmodule

/* rtl/radical_square_factor_search.sv */
// Top level: square-divisor search for simplifying a square root.
//
//   channel | ports                                        | dir
//   in      | in_valid, in_ready, in_radicand              | input beat
//   out     | out_valid, out_ready, out_kind, out_factor,  | result beat
//           | out_rest, out_last                           |
//
// One radicand at a time. Bit-pair square root first; then each candidate k
// from 2 to isqrt(n) is tried in turn in the bit-serial divider.
// Reset is synchronous, active low; nothing needs clearing afterwards.
// A found pair waits in a hold register; the search stalls only while the
// output register is full and a newer pair must push the held one out.
module radical_square_factor_search #(
  parameter int RADICAND_BITS = rsfs_pkg::RADICAND_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [RADICAND_BITS-1:0]      in_radicand,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rsfs_pkg::KIND_W-1:0]   out_kind,
  output logic [rsfs_pkg::FACTOR_W-1:0] out_factor,
  output logic [RADICAND_BITS-1:0]      out_rest,
  output logic                          out_last
);
  import rsfs_pkg::*;

  localparam int W     = RADICAND_BITS;
  localparam int H     = (W + 1) / 2;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQRT  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_PAIR  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [W-1:0]        n_r, n_nxt;
  logic [H-1:0]        s_r, s_nxt;
  logic [H-1:0]        k_r, k_nxt;
  logic [W-1:0]        sq_r, sq_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                div_go_r, div_go_nxt;
  logic [KIND_W-1:0]   hold_kind_r, hold_kind_nxt;
  logic [FACTOR_W-1:0] hold_factor_r, hold_factor_nxt;
  logic [W-1:0]        hold_rest_r, hold_rest_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [FACTOR_W-1:0] out_factor_r, out_factor_nxt;
  logic [W-1:0]        out_rest_r, out_rest_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_acc;
  logic                can_push;
  logic                push;
  logic                push_last;
  logic                k_end;
  logic [CNT_W-1:0]    cnt_inc;
  logic                sqrt_start;
  logic [H-1:0]        sq_root;
  rsfs_stat_t          sq_st;
  logic [W-1:0]        quot;
  rsfs_stat_t          dv_st;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign can_push   = !out_valid_r || out_ready;
  assign sqrt_start = in_acc && (in_radicand > W'(1));
  assign k_end      = (k_r == s_r);
  assign cnt_inc    = cnt_r + CNT_W'(1);

  rsfs_isqrt #(.W(W)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .n     (in_radicand),
    .root  (sq_root),
    .stat  (sq_st)
  );

  rsfs_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (n_r),
    .divisor  (sq_r),
    .quot     (quot),
    .stat     (dv_st)
  );

  always_comb begin
    state_nxt       = state_r;
    n_nxt           = n_r;
    s_nxt           = s_r;
    k_nxt           = k_r;
    sq_nxt          = sq_r;
    cnt_nxt         = cnt_r;
    div_go_nxt      = 1'b0;
    hold_kind_nxt   = hold_kind_r;
    hold_factor_nxt = hold_factor_r;
    hold_rest_nxt   = hold_rest_r;
    push            = 1'b0;
    push_last       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          n_nxt = in_radicand;
          if (in_radicand <= W'(1)) begin
            hold_kind_nxt   = KIND_EXACT;
            hold_factor_nxt = FACTOR_W'(in_radicand);
            hold_rest_nxt   = '0;
            state_nxt       = S_FINAL;
          end else begin
            state_nxt = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        if (sq_st.done) begin
          if (sq_st.zero) begin
            hold_kind_nxt   = KIND_EXACT;
            hold_factor_nxt = FACTOR_W'(sq_root);
            hold_rest_nxt   = '0;
            state_nxt       = S_FINAL;
          end else if (sq_root < H'(2)) begin
            hold_kind_nxt   = KIND_NONE;
            hold_factor_nxt = '0;
            hold_rest_nxt   = '0;
            state_nxt       = S_FINAL;
          end else begin
            s_nxt      = sq_root;
            k_nxt      = H'(2);
            sq_nxt     = W'(4);
            cnt_nxt    = '0;
            div_go_nxt = 1'b1;
            state_nxt  = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (dv_st.done) begin
          if (dv_st.zero && (cnt_r != '0)) begin
            state_nxt = S_PAIR;
          end else begin
            if (dv_st.zero) begin
              hold_kind_nxt   = KIND_PAIR;
              hold_factor_nxt = FACTOR_W'(k_r);
              hold_rest_nxt   = quot;
              cnt_nxt         = cnt_inc;
            end
            if (k_end || (dv_st.zero && (cnt_inc == CNT_W'(MAX_RESULTS)))) begin
              if (!dv_st.zero && (cnt_r == '0)) begin
                hold_kind_nxt   = KIND_NONE;
                hold_factor_nxt = '0;
                hold_rest_nxt   = '0;
              end
              state_nxt = S_FINAL;
            end else begin
              k_nxt      = k_r + H'(1);
              sq_nxt     = sq_r + W'({k_r, 1'b1});
              div_go_nxt = 1'b1;
            end
          end
        end
      end
      S_PAIR: begin
        if (can_push) begin
          push            = 1'b1;
          hold_kind_nxt   = KIND_PAIR;
          hold_factor_nxt = FACTOR_W'(k_r);
          hold_rest_nxt   = quot;
          cnt_nxt         = cnt_inc;
          if (k_end || (cnt_inc == CNT_W'(MAX_RESULTS))) begin
            state_nxt = S_FINAL;
          end else begin
            k_nxt      = k_r + H'(1);
            sq_nxt     = sq_r + W'({k_r, 1'b1});
            div_go_nxt = 1'b1;
            state_nxt  = S_DIV;
          end
        end
      end
      S_FINAL: begin
        if (can_push) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_factor_nxt = out_factor_r;
    out_rest_nxt   = out_rest_r;
    out_last_nxt   = out_last_r;
    if (push) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = hold_kind_r;
      out_factor_nxt = hold_factor_r;
      out_rest_nxt   = hold_rest_r;
      out_last_nxt   = push_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      div_go_r    <= div_go_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r           <= n_nxt;
    s_r           <= s_nxt;
    k_r           <= k_nxt;
    sq_r          <= sq_nxt;
    hold_kind_r   <= hold_kind_nxt;
    hold_factor_r <= hold_factor_nxt;
    hold_rest_r   <= hold_rest_nxt;
    out_kind_r    <= out_kind_nxt;
    out_factor_r  <= out_factor_nxt;
    out_rest_r    <= out_rest_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_factor = out_factor_r;
  assign out_rest   = out_rest_r;
  assign out_last   = out_last_r;

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_EXACT || out_kind == KIND_PAIR || out_kind == KIND_NONE))
    else $error("illegal result kind");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_PAIR) |-> out_last)
    else $error("exact or none beat without last");

  a_pair_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_PAIR) |-> (out_rest != '0) && (out_factor > FACTOR_W'(1)))
    else $error("bad factored pair");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("pair count past limit");

  a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sq_st.done |-> (state_r == S_SQRT))
    else $error("root done outside root phase");

endmodule

/* dv/radical_square_factor_search_tb.sv */
`timescale 1ns / 100ps
// Testbench for radical_square_factor_search: table-driven directed radicands, then random ones.
module radical_square_factor_search_tb;
  import rsfs_pkg::*;

  localparam int RB = RADICAND_BITS_DEF;
  localparam int NUM_ROWS = 16;
  localparam int NUM_RAND = 100;
  localparam int CALM_TAIL = 20;
  localparam int DRAIN_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 12_000_000;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [FACTOR_W-1:0] factor;
    logic [RB-1:0]       rest;
    logic                last;
  } root_term_t;

  typedef struct packed {
    logic [RB-1:0] radicand;
    logic          typed;
    root_term_t    term;
  } opening_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [RB-1:0]       in_radicand = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [KIND_W-1:0]   out_kind;
  logic [FACTOR_W-1:0] out_factor;
  logic [RB-1:0]       out_rest;
  logic                out_last;

  root_term_t    terms_due[$];
  root_term_t    want;
  opening_row_t  rows [NUM_ROWS];
  logic [RB-1:0] live_radicand = '0;
  logic          idle_on = 1'b1;
  int            mismatches = 0;
  longint        cycles = 0;

  radical_square_factor_search i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_radicand(in_radicand),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_factor (out_factor),
    .out_rest   (out_rest),
    .out_last   (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("%0t n=%0d mismatch: %s", $time, live_radicand, what);
  endtask

  function automatic root_term_t make_term(logic [KIND_W-1:0] kind, logic [63:0] factor,
                                           logic [63:0] rest, logic last);
    root_term_t t;
    t.kind   = kind;
    t.factor = factor[FACTOR_W-1:0];
    t.rest   = rest[RB-1:0];
    t.last   = last;
    return t;
  endfunction

  function automatic opening_row_t make_row(logic [RB-1:0] n, logic typed,
                                            logic [KIND_W-1:0] kind, logic [63:0] factor,
                                            logic [63:0] rest);
    opening_row_t r;
    r.radicand = n;
    r.typed    = typed;
    r.term     = make_term(kind, factor, rest, 1'b1);
    return r;
  endfunction

  function automatic void queue_term(input root_term_t t);
    terms_due.insert(terms_due.size(), t);
  endfunction

  // Queues every result term that one radicand produces.
  function automatic void simplify_radical(input logic [RB-1:0] n);
    logic [63:0] n64;
    logic [63:0] sq;
    logic [63:0] odd;
    logic [63:0] k;
    int          found;
    root_term_t  held;
    n64 = {{(64-RB){1'b0}}, n};
    if (n64 <= 64'd1) begin
      queue_term(make_term(KIND_EXACT, n64, 64'd0, 1'b1));
      return;
    end
    k = 64'd2;
    sq = 64'd4;
    odd = 64'd5;
    while (sq < n64) begin
      sq += odd;
      odd += 64'd2;
      k += 64'd1;
    end
    if (sq == n64) begin
      queue_term(make_term(KIND_EXACT, k, 64'd0, 1'b1));
      return;
    end
    found = 0;
    held = '0;
    k = 64'd2;
    sq = 64'd4;
    odd = 64'd5;
    while (sq < n64 && found < MAX_RESULTS) begin
      if (n64 % sq == 64'd0) begin
        if (found > 0) queue_term(held);
        held = make_term(KIND_PAIR, k, n64 / sq, 1'b0);
        found++;
      end
      sq += odd;
      odd += 64'd2;
      k += 64'd1;
    end
    if (found == 0) begin
      queue_term(make_term(KIND_NONE, 64'd0, 64'd0, 1'b1));
    end else begin
      held.last = 1'b1;
      queue_term(held);
    end
  endfunction

  task automatic send_radicand(input opening_row_t row);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_radicand <= row.radicand;
    do @(posedge clk); while (!in_ready);
    live_radicand = row.radicand;
    if (row.typed) begin
      queue_term(row.term);
    end else begin
      simplify_radical(row.radicand);
    end
  endtask

  initial begin
    @(posedge rst_n);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (terms_due.size() == 0) begin
        note_mismatch($sformatf("unexpected beat kind=%0d factor=%0d rest=%0d last=%0d",
                                out_kind, out_factor, out_rest, out_last));
      end else begin
        want = terms_due.pop_front();
        if (out_kind !== want.kind)
          note_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
        if (out_factor !== want.factor)
          note_mismatch($sformatf("factor %0d, want %0d", out_factor, want.factor));
        if (out_rest !== want.rest)
          note_mismatch($sformatf("rest %0d, want %0d", out_rest, want.rest));
        if (out_last !== want.last)
          note_mismatch($sformatf("last %0d, want %0d", out_last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned r;
    opening_row_t row;
    rows[0]  = make_row(31'd0, 1'b1, KIND_EXACT, 0, 0);
    rows[1]  = make_row(31'd1, 1'b1, KIND_EXACT, 1, 0);
    rows[2]  = make_row(31'd2, 1'b1, KIND_NONE, 0, 0);
    rows[3]  = make_row(31'd3, 1'b1, KIND_NONE, 0, 0);
    rows[4]  = make_row(31'd4, 1'b1, KIND_EXACT, 2, 0);
    rows[5]  = make_row(31'd8, 1'b1, KIND_PAIR, 2, 2);
    rows[6]  = make_row(31'd12, 1'b1, KIND_PAIR, 2, 3);
    rows[7]  = make_row(31'd36, 1'b0, KIND_EXACT, 0, 0);
    rows[8]  = make_row(31'd48, 1'b0, KIND_EXACT, 0, 0);
    rows[9]  = make_row(31'd72, 1'b0, KIND_EXACT, 0, 0);
    rows[10] = make_row(31'd1000, 1'b0, KIND_EXACT, 0, 0);
    rows[11] = make_row(31'd5040, 1'b0, KIND_EXACT, 0, 0);
    // 2^10 * 3^5 * 5^2 * 7^2: more square divisors than the result cap
    rows[12] = make_row(31'd304819200, 1'b0, KIND_EXACT, 0, 0);
    rows[13] = make_row(31'h4000_0000, 1'b1, KIND_EXACT, 32768, 0);
    rows[14] = make_row(31'd2147395600, 1'b1, KIND_EXACT, 46340, 0);
    // all ones is prime: full-length search, no square divisor
    rows[15] = make_row(31'h7fff_ffff, 1'b1, KIND_NONE, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_radicand(rows[i]);

    for (int i = 0; i < NUM_RAND; i++) begin
      if (i == NUM_RAND - CALM_TAIL) idle_on <= 1'b0;
      row = '0;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        row.radicand = RB'($urandom_range(0, 4095));
      end else if (pick < 70) begin
        r = $urandom_range(2, 40);
        row.radicand = RB'(r * r * $urandom_range(1, 60));
      end else if (pick < 85) begin
        r = $urandom_range(0, 46340);
        row.radicand = RB'(r * r);
      end else if (pick < 95) begin
        row.radicand = RB'($urandom_range(0, 65535));
      end else begin
        row.radicand = RB'($urandom_range(0, 4));
      end
      send_radicand(row);
    end
    in_valid <= 1'b0;

    while (terms_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
